@@ rtl/fcil_pkg.sv @@
// ----------------------------------------------------------------------------
// fcil_pkg: shared types and constants for the Fibonacci capacity list
// Holds the store depth, field widths, operation and status codes, and the
// structs that travel between the controller and the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fcil_pkg;

  // physical store depth and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  // read reduction: cells are OR-ed in groups, group results are registered
  localparam int GROUPS = 8;
  localparam int GRP_SZ = DEPTH / GROUPS;

  // operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // per-transaction commands broadcast to every cell
  typedef struct packed {
    logic             ins_en;   // shift/load this cycle
    logic [CNT_W-1:0] pos;      // insert position
    logic [CNT_W-1:0] cnt;      // count before the insert
    logic             rd_en;    // a cell drives its entry onto the read OR
    logic [CNT_W-1:0] rd_addr;  // cell to read
  } cell_ctrl_t;

  // bookkeeping part of one result
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/fcil_cell.sv @@
// ----------------------------------------------------------------------------
// fcil_cell: one storage cell of the list
// Holds one entry; on insert it either loads the new value, takes its left
// neighbor's entry, or keeps its own. Drives its entry onto the read OR when
// addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module fcil_cell (
  input  wire logic                        clk,
  input  wire logic [fcil_pkg::IDX_W-1:0]  cell_index,
  input  wire fcil_pkg::cell_ctrl_t        ctrl,
  input  wire logic [fcil_pkg::DATA_W-1:0] value,
  input  wire logic [fcil_pkg::DATA_W-1:0] left,
  output logic      [fcil_pkg::DATA_W-1:0] entry,
  output logic      [fcil_pkg::DATA_W-1:0] rd_data
);

  logic [fcil_pkg::CNT_W-1:0] my_pos;

  assign my_pos = fcil_pkg::CNT_W'(cell_index);

  // load at the insert point, shift up above it, hold elsewhere
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (my_pos == ctrl.pos) begin
        entry <= value;
      end else if (my_pos > ctrl.pos && my_pos <= ctrl.cnt) begin
        entry <= left;
      end
    end
  end

  // drive the read OR only when addressed
  assign rd_data = (ctrl.rd_en && my_pos == ctrl.rd_addr) ? entry : '0;

endmodule

`default_nettype wire

@@ rtl/fcil_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcil_ctrl: count and Fibonacci capacity controller
// Decodes each transaction, checks range, empty and full conditions, steps
// the capacity, and issues the insert and read commands to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module fcil_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [1:0]                 operation,
  input  wire logic [fcil_pkg::CNT_W-1:0] index,
  output fcil_pkg::cell_ctrl_t            ctrl,
  output fcil_pkg::res_t                  res
);

  localparam logic [fcil_pkg::CNT_W-1:0] DEPTH_C = fcil_pkg::CNT_W'(fcil_pkg::DEPTH);

  logic [fcil_pkg::CNT_W-1:0] stored_count, stored_count_next;
  logic [fcil_pkg::CNT_W-1:0] cap_current, cap_current_next;
  logic [fcil_pkg::CNT_W-1:0] cap_previous, cap_previous_next;
  logic [fcil_pkg::CNT_W-1:0] pos;
  logic [fcil_pkg::CNT_W-1:0] cnt_dec;
  logic [1:0]                 status;

  assign pos     = (operation == fcil_pkg::OP_PUSH) ? stored_count : index;
  assign cnt_dec = stored_count - fcil_pkg::CNT_W'(1);

  // decode one transaction
  always_comb begin
    stored_count_next = stored_count;
    cap_current_next  = cap_current;
    cap_previous_next = cap_previous;
    status            = fcil_pkg::ST_OK;
    ctrl.ins_en       = 1'b0;
    ctrl.pos          = pos;
    ctrl.cnt          = stored_count;
    ctrl.rd_en        = 1'b0;
    ctrl.rd_addr      = index;
    case (operation)
      fcil_pkg::OP_PUSH, fcil_pkg::OP_INSERT: begin
        if (pos > stored_count) begin
          status = fcil_pkg::ST_INDEX;
        end else if (stored_count >= DEPTH_C) begin
          status = fcil_pkg::ST_FULL;
        end else begin
          ctrl.ins_en       = accept;
          stored_count_next = stored_count + fcil_pkg::CNT_W'(1);
          if (stored_count_next > cap_current) begin
            cap_current_next  = cap_current + cap_previous;
            cap_previous_next = cap_current;
          end
        end
      end
      fcil_pkg::OP_LOOKUP: begin
        if (index >= stored_count) begin
          status = fcil_pkg::ST_INDEX;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      fcil_pkg::OP_POP: begin
        if (stored_count == '0) begin
          status = fcil_pkg::ST_EMPTY;
        end else begin
          ctrl.rd_en        = 1'b1;
          ctrl.rd_addr      = cnt_dec;
          stored_count_next = cnt_dec;
          if (cap_current >= cap_previous &&
              cnt_dec < (cap_current - cap_previous)) begin
            cap_current_next  = cap_previous;
            cap_previous_next = cap_current - cap_previous;
          end
        end
      end
      default: begin
        status = fcil_pkg::ST_OK;
      end
    endcase
  end

  assign res.status = status;
  assign res.count  = stored_count_next;
  assign res.cap    = cap_current_next;

  // hold count and capacity, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      cap_current  <= fcil_pkg::CNT_W'(1);
      cap_previous <= fcil_pkg::CNT_W'(1);
    end else if (accept) begin
      stored_count <= stored_count_next;
      cap_current  <= cap_current_next;
      cap_previous <= cap_previous_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fibonacci_capacity_insert_list.sv @@
// Results: a taken start is registered in stage one, then in stage two, which strobes done.
// Throughput: one transaction per cycle; busy stays low, the row of cells
//   shifts the entries above the insert point in the cycle of the insert and the read OR is split
//   over two register stages.
// Reset: rst clears the count to zero and the capacity pair to (1, 1);
//   stored entries are not cleared. Results are strobed and cannot be stalled.
`default_nettype none

module fibonacci_capacity_insert_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  operation,
  input  wire logic [fcil_pkg::DATA_W-1:0] value,
  input  wire logic [fcil_pkg::CNT_W-1:0]  index,
  output logic                             done,
  output logic      [1:0]                  status,
  output logic      [fcil_pkg::DATA_W-1:0] data,
  output logic      [fcil_pkg::CNT_W-1:0]  item_count,
  output logic      [fcil_pkg::CNT_W-1:0]  capacity_now
);

  logic                        accept;
  fcil_pkg::cell_ctrl_t        ctrl;
  fcil_pkg::res_t              res;
  logic [fcil_pkg::DATA_W-1:0] entry   [fcil_pkg::DEPTH];
  logic [fcil_pkg::DATA_W-1:0] cell_rd [fcil_pkg::DEPTH];
  logic [fcil_pkg::DATA_W-1:0] part_next [fcil_pkg::GROUPS];
  logic [fcil_pkg::DATA_W-1:0] part      [fcil_pkg::GROUPS];
  logic [fcil_pkg::DATA_W-1:0] data_next;
  logic                        valid1;
  fcil_pkg::res_t              res1;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  fcil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .index     (index),
    .ctrl      (ctrl),
    .res       (res)
  );

  // row of cells, each fed by its left neighbor
  for (genvar i = 0; i < fcil_pkg::DEPTH; i++) begin : g_cell
    fcil_cell u_cell (
      .clk        (clk),
      .cell_index (fcil_pkg::IDX_W'(i)),
      .ctrl       (ctrl),
      .value      (value),
      .left       ((i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1]),
      .entry      (entry[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // first level of the read OR, one term per group
  always_comb begin
    for (int g = 0; g < fcil_pkg::GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < fcil_pkg::GRP_SZ; k++) begin
        part_next[g] = part_next[g] | cell_rd[g * fcil_pkg::GRP_SZ + k];
      end
    end
  end

  // second level of the read OR
  always_comb begin
    data_next = '0;
    for (int g = 0; g < fcil_pkg::GROUPS; g++) begin
      data_next = data_next | part[g];
    end
  end

  // stage one: capture bookkeeping and group ORs
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
    res1 <= res;
    part <= part_next;
  end

  // stage two: strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid1;
    end
    status       <= res1.status;
    item_count   <= res1.count;
    capacity_now <= res1.cap;
    data         <= data_next;
  end

endmodule

`default_nettype wire

@@ rtl/fcil_checker.sv @@
// ----------------------------------------------------------------------------
// fcil_checker: port-level checks for the Fibonacci capacity list
// Watches the top level's ports for result timing and consistency of the
// reported count, capacity and data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcil_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [1:0]                  status,
  input wire logic [fcil_pkg::DATA_W-1:0] data,
  input wire logic [fcil_pkg::CNT_W-1:0]  item_count,
  input wire logic [fcil_pkg::CNT_W-1:0]  capacity_now
);

  // every accepted transaction yields a result strobe on done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> ##1 !done)
    else $error("result strobed without a transaction");

  // errors carry zero data
  a_err_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != fcil_pkg::ST_OK) |-> data == '0)
    else $error("error result carries nonzero data");

  // count never exceeds the capacity or the store, and the capacity is nonzero
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (item_count <= capacity_now &&
              item_count <= fcil_pkg::CNT_W'(fcil_pkg::DEPTH) &&
              capacity_now != '0))
    else $error("count outside capacity or store");

endmodule

bind fibonacci_capacity_insert_list fcil_checker u_fcil_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .data         (data),
  .item_count   (item_count),
  .capacity_now (capacity_now)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for fibonacci_capacity_insert_list
// Drives push, insert, lookup and pop commands, directed and then in random bursts, keeps its
// own model of the list and of the Fibonacci capacity pair, and compares
// every strobed result field by field against the expected one.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcil_pkg::*;

  localparam int NUM_RANDOM  = 1100;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_TICKS = 10;

  typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} traffic_mode_t;

  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  cap;
  } list_result_t;

  // Tracks list contents and capacity, and holds the results still owed
  class fib_list_predictor;
    logic [DATA_W-1:0] cells [DEPTH];
    int                count;
    int                cap_cur;
    int                cap_prev;
    int                errors;
    list_result_t      pending_results [$];

    function new();
      count    = 0;
      cap_cur  = 1;
      cap_prev = 1;
      errors   = 0;
    endfunction

    // Apply one accepted transaction and queue its expected result
    function void take_command(logic [1:0] op, logic [DATA_W-1:0] val,
                               logic [CNT_W-1:0] idx);
      list_result_t r;
      int           pos;
      int           old;
      r.status = ST_OK;
      r.data   = '0;
      case (op)
        OP_PUSH, OP_INSERT: begin
          pos = (op == OP_PUSH) ? count : int'(idx);
          if (pos > count) begin
            r.status = ST_INDEX;
          end else if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // grow one Fibonacci step when the new count would overflow
            if (count + 1 > cap_cur) begin
              old      = cap_cur;
              cap_cur  = cap_cur + cap_prev;
              cap_prev = old;
            end
            for (int j = count; j > pos; j--) cells[j] = cells[j-1];
            cells[pos] = val;
            count++;
          end
        end
        OP_LOOKUP: begin
          if (int'(idx) >= count) r.status = ST_INDEX;
          else r.data = cells[idx];
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count--;
            r.data = cells[count];
            // shrink one step once the count drops below the lower band
            if (count < cap_cur - cap_prev) begin
              old      = cap_prev;
              cap_prev = cap_cur - cap_prev;
              cap_cur  = old;
            end
          end
        end
      endcase
      r.count = count[CNT_W-1:0];
      r.cap   = cap_cur[CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    // Compare one strobed result with the oldest expectation
    function void check_result(logic [1:0] st, logic [DATA_W-1:0] d,
                               logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] cap);
      list_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (d !== e.data) begin
        $error("data: expected %h, got %h", e.data, d);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("item_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
      if (cap !== e.cap) begin
        $error("capacity_now: expected %0d, got %0d", e.cap, cap);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        operation;
  logic [DATA_W-1:0] value;
  logic [CNT_W-1:0]  index;
  logic              done;
  logic [1:0]        status;
  logic [DATA_W-1:0] data;
  logic [CNT_W-1:0]  item_count;
  logic [CNT_W-1:0]  capacity_now;

  fib_list_predictor sb = new();
  int                burst_left;
  int                idle_ticks;

  fibonacci_capacity_insert_list dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value        (value),
    .index        (index),
    .done         (done),
    .status       (status),
    .data         (data),
    .item_count   (item_count),
    .capacity_now (capacity_now)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Record accepted transactions and check strobed results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.take_command(operation, value, index);
      if (done) sb.check_result(status, data, item_count, capacity_now);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

  // Issue one transaction; called at a falling edge, returns at a falling edge
  task automatic send(logic [1:0] op, logic [DATA_W-1:0] val, logic [CNT_W-1:0] idx);
    int gap;
    // insert a random gap between bursts, sometimes none
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) begin
        gap   = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    index     <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build one random transaction weighted by the traffic mode
  task automatic send_random(traffic_mode_t mode);
    int         r;
    int         cnt;
    logic [1:0] op;
    logic [6:0] idx;
    r   = $urandom_range(99);
    cnt = sb.count;
    case (mode)
      MODE_GROW:   op = (r < 45) ? OP_PUSH : (r < 85) ? OP_INSERT :
                        (r < 93) ? OP_LOOKUP : OP_POP;
      MODE_SHRINK: op = (r < 80) ? OP_POP : (r < 88) ? OP_PUSH :
                        (r < 94) ? OP_INSERT : OP_LOOKUP;
      default:     op = 2'(r % 4);
    endcase
    idx = 7'($urandom_range(127));
    // keep most indexes legal, leave some out of range
    if (op == OP_INSERT && $urandom_range(9) != 0) idx = 7'($urandom_range(cnt));
    if (op == OP_LOOKUP && $urandom_range(7) != 0 && cnt > 0)
      idx = 7'($urandom_range(cnt - 1));
    send(op, pick_value(), idx);
  endtask

  initial begin
    traffic_mode_t mode;
    int            run_len;
    int            issued;
    rst        = 1'b1;
    start      = 1'b0;
    operation  = OP_PUSH;
    value      = '0;
    index      = '0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list errors, extreme values, edge indexes, drain to empty
    send(OP_POP,    32'h0,         7'd0);
    send(OP_LOOKUP, 32'h0,         7'd0);
    send(OP_LOOKUP, 32'hFFFF_FFFF, 7'd127);
    send(OP_INSERT, 32'h1234_5678, 7'd1);
    send(OP_INSERT, 32'h7FFF_FFFF, 7'd0);
    send(OP_PUSH,   32'h8000_0000, 7'd127);
    send(OP_PUSH,   32'h0000_0000, 7'd0);
    send(OP_PUSH,   32'hFFFF_FFFF, 7'd64);
    send(OP_INSERT, 32'h5555_5555, 7'd2);
    send(OP_INSERT, 32'hAAAA_AAAA, 7'd5);
    send(OP_INSERT, 32'h0F0F_0F0F, 7'd7);
    send(OP_INSERT, 32'h0000_0001, 7'd0);
    send(OP_LOOKUP, 32'h0,         7'd0);
    send(OP_LOOKUP, 32'h0,         7'd6);
    send(OP_LOOKUP, 32'h0,         7'd7);
    send(OP_LOOKUP, 32'h0,         7'd64);
    repeat (7) send(OP_POP, 32'hFFFF_FFFF, 7'd127);

    // Random: cycle through fill, mixed and drain phases
    issued = 0;
    mode   = MODE_GROW;
    while (issued < NUM_RANDOM) begin
      case (mode)
        MODE_GROW:   run_len = $urandom_range(100, 130);
        MODE_SHRINK: run_len = $urandom_range(110, 140);
        default:     run_len = $urandom_range(60, 100);
      endcase
      repeat (run_len) send_random(mode);
      issued += run_len;
      case (mode)
        MODE_GROW:  mode = MODE_MIXED;
        MODE_MIXED: mode = MODE_SHRINK;
        default:    mode = MODE_GROW;
      endcase
    end

    // Drain outstanding results, then watch for strays
    start <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fcil_pkg.sv
rtl/fcil_cell.sv
rtl/fcil_ctrl.sv
rtl/fibonacci_capacity_insert_list.sv
rtl/fcil_checker.sv
tb/tb.sv
